[hdl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every rising edge outside reset.
`define URW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Check a property on every rising edge, reset included.
`define URW_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`endif

[hdl/urw_pkg.sv]
// Shared types and constants of the reorder window.
package urw_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int IN_W         = 64;
    localparam int SEQ_W        = 32;
    localparam int HND_W        = 16;
    localparam int FREE_W       = 8;
    localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

    typedef enum logic [1:0] {
        FN_SEND    = 2'd0,
        FN_INSERT  = 2'd1,
        FN_RELEASE = 2'd2,
        FN_NACK    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_OLD     = 3'd1,
        ST_TOO_NEW = 3'd2,
        ST_DUP     = 3'd3,
        ST_NONE    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_REL  = 2'd1,
        S_NACK = 2'd2
    } t_state;

    typedef struct packed {
        t_func             func;
        logic [SEQ_W-1:0]  seq;
        logic [HND_W-1:0]  handle;
        logic [FREE_W-1:0] free_words;
    } t_item;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

endpackage

[hdl/udp_reorder_window_with_nack.sv]
// Top level: receive reorder window with send counter and NACK list builder.
//
// Input channel (i_s_*): one beat per command. tdata carries func, seq_in,
// pkt_handle and free_words. func 0 returns the next send number, func 1
// inserts a packet handle, func 2 releases the next in-order handle, func 3
// builds a NACK list of missing numbers.
// Output channel (o_m_*): tdata is the value word, tuser the status, tlast
// marks the final beat of a command. Each command gives one beat, except
// func 3, which gives up to WINDOW_DEPTH beats.
// A command is decoded into a two-entry queue, from which the engine takes
// it; the result register then shows its result. Send, insert and a
// rejected release or NACK are done in the idle state; a release also
// passes the release state after a registered handle store read; a NACK
// list passes the scan state once per scanned number and once to close.
// Reset clears the window, sets both counters to one and disarms the NACK
// builder. When the receiver stalls, the result register holds, the engine
// stops, and the input queue fills and then drops tready.
module udp_reorder_window_with_nack
    import urw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // func[1:0], seq_in[33:2], pkt_handle[49:34], free_words[57:50], zero[63:58]
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [SEQ_W-1:0] o_m_tdata,   // out_value[31:0]
    output logic [2:0]       o_m_tuser,   // out_status[2:0]
    output logic             o_m_tlast
);

    logic  w_valid;
    t_item w_item;
    logic  w_pop;

    urw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_valid    (w_valid),
        .o_item     (w_item),
        .i_pop      (w_pop)
    );

    urw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid),
        .i_item     (w_item),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

[hdl/urw_front.sv]
// Input side: accepts beats, decodes them and queues them for the engine.
module urw_front
    import urw_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [IN_W-1:0] i_s_tdata,
    output logic            o_valid,
    output t_item           o_item,
    input  logic            i_pop
);
`include "assert_macros.svh"

    t_item       r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        w_push;
    t_item       w_item;

    assign o_s_tready = (r_cnt != 2'd2);
    assign w_push     = i_s_tvalid && o_s_tready;
    assign o_valid    = (r_cnt != 2'd0);
    assign o_item     = r_q[r_rp];

    always_comb begin
        w_item.func       = t_func'(i_s_tdata[1:0]);
        w_item.seq        = i_s_tdata[33:2];
        w_item.handle     = i_s_tdata[49:34];
        w_item.free_words = i_s_tdata[57:50];
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

    `URW_ASSERT(a_pop_nonempty, i_pop |-> (r_cnt != 2'd0), "pop from empty queue")
    `URW_ASSERT(a_cnt_range, r_cnt != 2'd3, "queue count out of range")

endmodule

[hdl/urw_back.sv]
// Engine: window state, handle store, NACK scan and output register.
module urw_back
    import urw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_item            i_item,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [SEQ_W-1:0] o_m_tdata,
    output logic [2:0]       o_m_tuser,
    output logic             o_m_tlast
);
`include "assert_macros.svh"

    t_state              r_state, n_state;
    logic [SEQ_W-1:0]    r_send, n_send;
    logic [SEQ_W-1:0]    r_fm, n_fm;
    logic [IDX_W-1:0]    r_fm_idx, n_fm_idx;
    logic [SEQ_W-1:0]    r_largest, n_largest;
    logic                r_armed, n_armed;
    logic [SEQ_W-1:0]    r_n, n_n;
    logic [IDX_W-1:0]    r_n_idx, n_n_idx;
    logic [FREE_W-1:0]   r_free, n_free;
    logic [WINDOW_DEPTH-1:0] r_full, n_full;
    logic [HND_W-1:0]    r_mem [WINDOW_DEPTH];
    logic [HND_W-1:0]    r_rd;
    logic                r_ov;
    logic [SEQ_W-1:0]    r_oval;
    t_status             r_ost;
    logic                r_olast;

    logic                w_go;
    logic                w_load;
    logic [SEQ_W-1:0]    w_val;
    t_status             w_st;
    logic                w_last;
    logic                w_we;
    logic                w_re;
    logic [SEQ_W-1:0]    w_diff;
    logic [IDX_W:0]      w_sum;
    logic [IDX_W-1:0]    w_ins_idx;

    assign w_go   = !r_ov || i_m_tready;
    assign w_diff = i_item.seq - r_fm;
    assign w_sum  = {1'b0, r_fm_idx} + {1'b0, w_diff[IDX_W-1:0]};
    assign w_ins_idx = (w_sum >= (IDX_W+1)'(WINDOW_DEPTH))
        ? IDX_W'(w_sum - (IDX_W+1)'(WINDOW_DEPTH)) : w_sum[IDX_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_send    = r_send;
        n_fm      = r_fm;
        n_fm_idx  = r_fm_idx;
        n_largest = r_largest;
        n_armed   = r_armed;
        n_n       = r_n;
        n_n_idx   = r_n_idx;
        n_free    = r_free;
        n_full    = r_full;
        o_pop     = 1'b0;
        w_load    = 1'b0;
        w_val     = '0;
        w_st      = ST_OK;
        w_last    = 1'b1;
        w_we      = 1'b0;
        w_re      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && w_go) begin
                    o_pop = 1'b1;
                    unique case (i_item.func)
                        FN_SEND: begin
                            w_load = 1'b1;
                            w_val  = r_send;
                            if (r_send != SEQ_MAX) begin
                                n_send = r_send + 1'b1;
                            end
                        end
                        FN_INSERT: begin
                            w_load = 1'b1;
                            if (i_item.seq < r_fm) begin
                                w_st = ST_OLD;
                            end else if (w_diff >= SEQ_W'(WINDOW_DEPTH)) begin
                                w_st = ST_TOO_NEW;
                            end else if (r_full[w_ins_idx]) begin
                                w_st = ST_DUP;
                            end else begin
                                w_we              = 1'b1;
                                n_full[w_ins_idx] = 1'b1;
                                n_armed           = 1'b1;
                                if (i_item.seq > r_largest) begin
                                    n_largest = i_item.seq;
                                end
                            end
                        end
                        FN_RELEASE: begin
                            if (r_full[r_fm_idx]) begin
                                w_re    = 1'b1;
                                n_state = S_REL;
                            end else begin
                                w_load = 1'b1;
                                w_st   = ST_NONE;
                            end
                        end
                        FN_NACK: begin
                            if (!r_armed || i_item.free_words == '0 ||
                                (r_fm <= SEQ_W'(1) && i_item.free_words < FREE_W'(2))) begin
                                w_load = 1'b1;
                                w_st   = ST_NONE;
                            end else begin
                                n_n     = r_fm;
                                n_n_idx = r_fm_idx;
                                n_free  = i_item.free_words;
                                n_state = S_NACK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_REL: begin
                if (w_go) begin
                    w_load           = 1'b1;
                    w_val            = SEQ_W'(r_rd);
                    n_full[r_fm_idx] = 1'b0;
                    if (r_fm != SEQ_MAX) begin
                        n_fm     = r_fm + 1'b1;
                        n_fm_idx = idx_inc(r_fm_idx);
                    end
                    n_state = S_IDLE;
                end
            end
            S_NACK: begin
                if (w_go) begin
                    if (r_free >= FREE_W'(2)) begin
                        if (r_n >= r_largest) begin
                            w_load  = 1'b1;
                            w_val   = r_largest;
                            n_state = S_IDLE;
                        end else begin
                            if (!r_full[r_n_idx]) begin
                                w_load = 1'b1;
                                w_val  = r_n;
                                w_last = 1'b0;
                                n_free = r_free - 1'b1;
                            end
                            n_n     = r_n + 1'b1;
                            n_n_idx = idx_inc(r_n_idx);
                        end
                    end else begin
                        w_load  = 1'b1;
                        w_val   = r_n - 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_ins_idx] <= i_item.handle;
        end
        if (w_re) begin
            r_rd <= r_mem[r_fm_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_oval  <= w_val;
            r_ost   <= w_st;
            r_olast <= w_last;
        end
        r_n     <= n_n;
        r_n_idx <= n_n_idx;
        r_free  <= n_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_send    <= SEQ_W'(1);
            r_fm      <= SEQ_W'(1);
            r_fm_idx  <= IDX_W'(1 % WINDOW_DEPTH);
            r_largest <= '0;
            r_armed   <= 1'b0;
            r_full    <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_send    <= n_send;
            r_fm      <= n_fm;
            r_fm_idx  <= n_fm_idx;
            r_largest <= n_largest;
            r_armed   <= n_armed;
            r_full    <= n_full;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_oval;
    assign o_m_tuser  = r_ost;
    assign o_m_tlast  = r_olast;

    `URW_ASSERT(a_nack_armed, (r_state == S_NACK) |-> r_armed, "NACK scan while not armed")
    `URW_ASSERT(a_fm_nonzero, r_fm != '0, "first missing number reached zero")
    `URW_ASSERT(a_scan_ends_last, ($past(r_state) == S_NACK && r_state == S_IDLE) |-> (r_ov && r_olast), "NACK list closed without last word")

endmodule
